>>> rtl/gwc_pkg.sv
// Shared types and constants for the grid word and cross counter.
// Holds the item structs, register map and widths; depends on nothing.
package gwc_pkg;

   localparam int MAX_WIDTH = 256;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int WID_W     = $clog2(MAX_WIDTH + 1);
   localparam int CHAR_W    = 8;
   localparam int TOTAL_W   = 24;
   localparam int ROWW_W    = 9;
   localparam int DSUM_W    = 9;
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 32;
   localparam int MAX_WORDS = 8;

   typedef enum logic [ADDR_W-3:0] {
      REG_ROW_WIDTH      = 3'd0,
      REG_PATTERN_FIRST  = 3'd1,
      REG_PATTERN_SECOND = 3'd2,
      REG_PATTERN_THIRD  = 3'd3,
      REG_PATTERN_FOURTH = 3'd4,
      REG_DIAGONAL_SUM   = 3'd5
   } reg_idx_type;

   localparam logic [ROWW_W-1:0] RST_ROW_WIDTH    = 9'd140;
   localparam logic [CHAR_W-1:0] RST_PAT_FIRST    = 8'd88;
   localparam logic [CHAR_W-1:0] RST_PAT_SECOND   = 8'd77;
   localparam logic [CHAR_W-1:0] RST_PAT_THIRD    = 8'd65;
   localparam logic [CHAR_W-1:0] RST_PAT_FOURTH   = 8'd83;
   localparam logic [DSUM_W-1:0] RST_DIAGONAL_SUM = 9'd160;

   typedef struct packed {
      logic [CHAR_W-1:0] grid_char;
      logic              grid_last;
   } req_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] word_total;
      logic [TOTAL_W-1:0] cross_total;
      logic               grid_done;
   } rsp_type;

   // One grid column: rows three, two and one above the current row.
   typedef struct packed {
      logic [CHAR_W-1:0] h2;
      logic [CHAR_W-1:0] h1;
      logic [CHAR_W-1:0] h0;
   } col_type;

   // Anti-diagonal cells above and to the right of a column, far end first.
   typedef struct packed {
      logic [CHAR_W-1:0] far;
      logic [CHAR_W-1:0] mid;
      logic [CHAR_W-1:0] near;
   } diag_type;

endpackage

>>> rtl/grid_word_and_cross_counter.sv
// Grid word and cross counter top level: column memory, anti-diagonal memory,
// match logic, running totals, output skid stage and register port. Uses gwc_pkg.
//
//   port group | direction | handshake             | carries
//   req_*      | in        | req_valid/req_ready   | grid_char, grid_last
//   rsp_*      | out       | rsp_valid/rsp_ready   | word_total, cross_total, grid_done
//   csr_*      | in/out    | APB psel/penable      | six configuration registers
//
// One item per cycle unless the skid entry is full; results are registered outputs.
// Throughput is set by the column memory, read one position ahead and written
// back when the item is accepted, with a bypass for a read of the entry just written.
// The cycle after a register write accepts no item while the prefetch address settles.
// Reset is synchronous and needs no clearing pass; a two-entry output stage absorbs stalls.
module grid_word_and_cross_counter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  gwc_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output gwc_pkg::rsp_type            rsp_data,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [gwc_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [gwc_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [gwc_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import gwc_pkg::*;

   logic [ROWW_W-1:0]  row_width_ff;
   logic [CHAR_W-1:0]  pat_first_ff, pat_second_ff, pat_third_ff, pat_fourth_ff;
   logic [DSUM_W-1:0]  dsum_ff;
   logic               hold_ff;
   logic               csr_wr;
   reg_idx_type        csr_idx;

   logic [WID_W-1:0]   width_eff;
   logic [COL_W-1:0]   pos_ff, pos_in;
   logic [1:0]         rows_ff, rows_in, rows_cur;
   logic [TOTAL_W-1:0] word_ff, word_in, cross_ff, cross_in;
   logic [CHAR_W-1:0]  l1_ff, l2_ff, l3_ff;
   col_type            p1_ff, p2_ff, p3_ff;

   col_type            col_mem [MAX_WIDTH];
   diag_type           diag_mem [MAX_WIDTH];
   col_type            col_rd_ff, col_byp_ff, col_rd, col_wr;
   diag_type           diag_rd_ff, diag_byp_ff, diag_rd, diag_wr;
   logic               col_sel_ff, diag_sel_ff;
   logic [COL_W-1:0]   rd_addr, diag_waddr;
   logic               diag_we;

   logic               accept, pre_wrap, wrap_end, full_rows;
   logic [COL_W-1:0]   col;
   logic [CHAR_W-1:0]  cur;
   logic [1:0]         h_hor, h_ver, h_dia, h_anti;
   logic [3:0]         words;
   logic               cross_hit;
   logic [TOTAL_W:0]   word_sum, cross_sum;
   rsp_type            result;

   logic               out_valid_ff, skid_valid_ff;
   rsp_type            out_ff, skid_ff;

   function automatic logic [1:0] line_hits(
      input logic [CHAR_W-1:0] a0, a1, a2, a3,
      input logic [CHAR_W-1:0] p0, p1, p2, p3
   );
      logic fwd, rev;
      fwd = (a0 == p0) && (a1 == p1) && (a2 == p2) && (a3 == p3);
      rev = (a3 == p0) && (a2 == p1) && (a1 == p2) && (a0 == p3);
      return {1'b0, fwd} + {1'b0, rev};
   endfunction

   // Register port.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = reg_idx_type'(csr_paddr[ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff  <= RST_ROW_WIDTH;
         pat_first_ff  <= RST_PAT_FIRST;
         pat_second_ff <= RST_PAT_SECOND;
         pat_third_ff  <= RST_PAT_THIRD;
         pat_fourth_ff <= RST_PAT_FOURTH;
         dsum_ff       <= RST_DIAGONAL_SUM;
         hold_ff       <= 1'b0;
      end else begin
         hold_ff <= csr_wr;
         if (csr_wr) begin
            unique case (csr_idx)
               REG_ROW_WIDTH:      row_width_ff  <= csr_pwdata[ROWW_W-1:0];
               REG_PATTERN_FIRST:  pat_first_ff  <= csr_pwdata[CHAR_W-1:0];
               REG_PATTERN_SECOND: pat_second_ff <= csr_pwdata[CHAR_W-1:0];
               REG_PATTERN_THIRD:  pat_third_ff  <= csr_pwdata[CHAR_W-1:0];
               REG_PATTERN_FOURTH: pat_fourth_ff <= csr_pwdata[CHAR_W-1:0];
               REG_DIAGONAL_SUM:   dsum_ff       <= csr_pwdata[DSUM_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_ROW_WIDTH:      csr_prdata = DATA_W'(row_width_ff);
         REG_PATTERN_FIRST:  csr_prdata = DATA_W'(pat_first_ff);
         REG_PATTERN_SECOND: csr_prdata = DATA_W'(pat_second_ff);
         REG_PATTERN_THIRD:  csr_prdata = DATA_W'(pat_third_ff);
         REG_PATTERN_FOURTH: csr_prdata = DATA_W'(pat_fourth_ff);
         REG_DIAGONAL_SUM:   csr_prdata = DATA_W'(dsum_ff);
         default:            csr_prdata = '0;
      endcase
   end

   always_comb begin
      if (row_width_ff == '0) begin
         width_eff = WID_W'(1);
      end else if (32'(row_width_ff) > 32'(MAX_WIDTH)) begin
         width_eff = WID_W'(MAX_WIDTH);
      end else begin
         width_eff = WID_W'(row_width_ff);
      end
   end

   // Position of the item at the port.
   assign accept    = req_valid && req_ready;
   assign cur       = req_data.grid_char;
   assign pre_wrap  = WID_W'(pos_ff) >= width_eff;
   assign col       = pre_wrap ? '0 : pos_ff;
   assign rows_cur  = (pre_wrap && rows_ff != 2'd3) ? rows_ff + 2'd1 : rows_ff;
   assign wrap_end  = (WID_W'(col) + WID_W'(1)) >= width_eff;
   assign full_rows = rows_cur == 2'd3;

   assign col_rd  = col_sel_ff  ? col_byp_ff  : col_rd_ff;
   assign diag_rd = diag_sel_ff ? diag_byp_ff : diag_rd_ff;

   // Matching.
   always_comb begin
      h_hor  = '0;
      h_ver  = '0;
      h_dia  = '0;
      h_anti = '0;
      if (col >= COL_W'(3)) begin
         h_hor = line_hits(l3_ff, l2_ff, l1_ff, cur,
                           pat_first_ff, pat_second_ff, pat_third_ff, pat_fourth_ff);
      end
      if (full_rows) begin
         h_ver = line_hits(col_rd.h2, col_rd.h1, col_rd.h0, cur,
                           pat_first_ff, pat_second_ff, pat_third_ff, pat_fourth_ff);
         if (col >= COL_W'(3)) begin
            h_dia = line_hits(p3_ff.h2, p2_ff.h1, p1_ff.h0, cur,
                              pat_first_ff, pat_second_ff, pat_third_ff, pat_fourth_ff);
         end
         if (((WID_W + 1)'(col) + (WID_W + 1)'(3)) < (WID_W + 1)'(width_eff)) begin
            h_anti = line_hits(diag_rd.far, diag_rd.mid, diag_rd.near, cur,
                               pat_first_ff, pat_second_ff, pat_third_ff, pat_fourth_ff);
         end
      end
      words = 4'(h_hor) + 4'(h_ver) + 4'(h_dia) + 4'(h_anti);
   end

   assign cross_hit = (rows_cur >= 2'd2) && (col >= COL_W'(2)) &&
                      (p1_ff.h0 == pat_third_ff) &&
                      ((DSUM_W'(p2_ff.h1) + DSUM_W'(cur)) == dsum_ff) &&
                      ((DSUM_W'(l2_ff) + DSUM_W'(col_rd.h1)) == dsum_ff);

   assign word_sum  = {1'b0, word_ff} + (TOTAL_W + 1)'(words);
   assign cross_sum = {1'b0, cross_ff} + (TOTAL_W + 1)'(cross_hit);

   always_comb begin
      result.word_total  = word_sum[TOTAL_W]  ? '1 : word_sum[TOTAL_W-1:0];
      result.cross_total = cross_sum[TOTAL_W] ? '1 : cross_sum[TOTAL_W-1:0];
      result.grid_done   = req_data.grid_last;
   end

   // Next grid state.
   always_comb begin
      pos_in   = pos_ff;
      rows_in  = rows_ff;
      word_in  = word_ff;
      cross_in = cross_ff;
      if (accept) begin
         if (req_data.grid_last) begin
            pos_in   = '0;
            rows_in  = '0;
            word_in  = '0;
            cross_in = '0;
         end else begin
            word_in  = result.word_total;
            cross_in = result.cross_total;
            if (wrap_end) begin
               pos_in  = '0;
               rows_in = (rows_cur != 2'd3) ? rows_cur + 2'd1 : rows_cur;
            end else begin
               pos_in  = col + COL_W'(1);
               rows_in = rows_cur;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         rows_ff  <= '0;
         word_ff  <= '0;
         cross_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         rows_ff  <= rows_in;
         word_ff  <= word_in;
         cross_ff <= cross_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         l1_ff <= cur;
         l2_ff <= l1_ff;
         l3_ff <= l2_ff;
         p1_ff <= col_rd;
         p2_ff <= p1_ff;
         p3_ff <= p2_ff;
      end
   end

   // Memories: prefetch the column of the next item, bypass a same-entry write.
   assign rd_addr    = (WID_W'(pos_in) >= width_eff) ? '0 : pos_in;
   assign col_wr     = '{h2: col_rd.h1, h1: col_rd.h0, h0: cur};
   assign diag_wr    = '{far: col_rd.h1, mid: p1_ff.h0, near: l2_ff};
   assign diag_we    = accept && (col >= COL_W'(3));
   assign diag_waddr = col - COL_W'(3);

   always_ff @(posedge clock) begin
      if (accept) begin
         col_mem[col] <= col_wr;
      end
      col_rd_ff <= col_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (diag_we) begin
         diag_mem[diag_waddr] <= diag_wr;
      end
      diag_rd_ff <= diag_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      col_byp_ff  <= col_wr;
      diag_byp_ff <= diag_wr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_sel_ff  <= 1'b0;
         diag_sel_ff <= 1'b0;
      end else begin
         col_sel_ff  <= accept && (col == rd_addr);
         diag_sel_ff <= diag_we && (diag_waddr == rd_addr);
      end
   end

   // Output register with skid entry.
   assign req_ready = !skid_valid_ff && !hold_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         priority if (!out_valid_ff || rsp_ready) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= accept;
            end
         end else begin
            if (accept) begin
               skid_valid_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      priority if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (accept) begin
            out_ff <= result;
         end
      end else begin
         if (accept) begin
            skid_ff <= result;
         end
      end
   end

endmodule

>>> rtl/gwc_checker.sv
// Port-level checks for the grid word and cross counter, bound to the top level.
// Uses gwc_pkg for the item types.
module gwc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input gwc_pkg::rsp_type rsp_data,
   input logic             csr_psel,
   input logic             csr_penable,
   input logic             csr_pwrite,
   input logic             csr_pready
);
   import gwc_pkg::*;

   logic [2:0] pending_ff;
   logic       fresh_ff;
   rsp_type    prev_ff;
   logic       in_acc, out_acc, csr_wr;

   assign in_acc  = req_valid && req_ready;
   assign out_acc = rsp_valid && rsp_ready;
   assign csr_wr  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         fresh_ff   <= 1'b1;
      end else begin
         pending_ff <= pending_ff + 3'(in_acc) - 3'(out_acc);
         if (out_acc) begin
            fresh_ff <= rsp_data.grid_done;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_acc) begin
         prev_ff <= rsp_data;
      end
   end

   // At most two items are held between acceptance and delivery.
   a_pending : assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd2)
      else $error("more than two items outstanding");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_cfg_gap : assert property (@(posedge clock) disable iff (reset)
      csr_wr |=> !req_ready)
      else $error("item taken right after a register write");

   // Within a grid the totals grow by at most one item's worth of matches.
   a_step : assert property (@(posedge clock) disable iff (reset)
      out_acc && !fresh_ff |->
         (rsp_data.word_total >= prev_ff.word_total) &&
         ((rsp_data.word_total - prev_ff.word_total) <= TOTAL_W'(MAX_WORDS)) &&
         (rsp_data.cross_total >= prev_ff.cross_total) &&
         ((rsp_data.cross_total - prev_ff.cross_total) <= TOTAL_W'(1)))
      else $error("totals stepped wrongly within a grid");

   a_restart : assert property (@(posedge clock) disable iff (reset)
      out_acc && fresh_ff |->
         (rsp_data.word_total <= TOTAL_W'(MAX_WORDS)) &&
         (rsp_data.cross_total <= TOTAL_W'(1)))
      else $error("totals not cleared at grid start");

endmodule

bind grid_word_and_cross_counter gwc_checker u_gwc_checker (.*);

>>> test/gwc_total_checker.sv
// Checker for the grid word and cross counter: follows register writes, predicts
// the running word and cross totals for every item and compares each result in order.
// Depends on gwc_pkg for the item structs, register indexes and field widths.
module gwc_total_checker
   import gwc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  req_type           req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  rsp_type           rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   input  logic [DATA_W-1:0] csr_prdata,
   input  logic              csr_pready,
   output int                fail_count,
   output int                pending_count
);

   localparam int TOTAL_MAX = (1 << TOTAL_W) - 1;

   logic [ROWW_W-1:0] row_width;
   logic [CHAR_W-1:0] pat_first, pat_second, pat_third, pat_fourth;
   logic [DSUM_W-1:0] diag_sum;

   logic [CHAR_W-1:0] col_hist [3][MAX_WIDTH];
   logic [CHAR_W-1:0] shifted_out [3];
   int                col_pos;
   int                rows_done;
   logic [TOTAL_W-1:0] word_sum, cross_sum;
   rsp_type           totals_q [$];
   int                errors = 0;

   function automatic int line_matches(input logic [CHAR_W-1:0] a0, a1, a2, a3);
      int n;
      n = 0;
      if (a0 == pat_first && a1 == pat_second && a2 == pat_third && a3 == pat_fourth)
         n++;
      if (a3 == pat_first && a2 == pat_second && a1 == pat_third && a0 == pat_fourth)
         n++;
      return n;
   endfunction

   function automatic void clear_grid();
      for (int k = 0; k < 3; k++) begin
         for (int c = 0; c < MAX_WIDTH; c++)
            col_hist[k][c] = '0;
         shifted_out[k] = '0;
      end
      col_pos   = 0;
      rows_done = 0;
      word_sum  = '0;
      cross_sum = '0;
   endfunction

   function automatic void note_failure(input string text);
      errors++;
      if (errors <= 10)
         $display("%s", text);
   endfunction

   task automatic advance_grid(input req_type item_in, output rsp_type totals);
      int w, c, words, crosses, next_sum;
      logic [CHAR_W-1:0] cur, evicted;
      cur = item_in.grid_char;
      w = int'(row_width);
      if (w < 1)
         w = 1;
      if (w > MAX_WIDTH)
         w = MAX_WIDTH;
      // A width shrunk below the current position starts a new row.
      if (col_pos >= w) begin
         col_pos = 0;
         if (rows_done < 3)
            rows_done++;
      end
      c = col_pos;
      words = 0;
      crosses = 0;
      if (c >= 3)
         words += line_matches(col_hist[0][c-3], col_hist[0][c-2], col_hist[0][c-1], cur);
      if (rows_done >= 3) begin
         words += line_matches(col_hist[2][c], col_hist[1][c], col_hist[0][c], cur);
         if (c >= 3)
            words += line_matches(shifted_out[2], col_hist[2][c-2], col_hist[1][c-1], cur);
         if (c + 3 < w)
            words += line_matches(col_hist[2][c+3], col_hist[1][c+2], col_hist[0][c+1], cur);
      end
      if (rows_done >= 2 && c >= 2) begin
         if (col_hist[1][c-1] == pat_third &&
             int'(col_hist[2][c-2]) + int'(cur) == int'(diag_sum) &&
             int'(col_hist[0][c-2]) + int'(col_hist[1][c]) == int'(diag_sum))
            crosses = 1;
      end

      evicted = col_hist[2][c];
      col_hist[2][c] = col_hist[1][c];
      col_hist[1][c] = col_hist[0][c];
      col_hist[0][c] = cur;
      shifted_out[2] = shifted_out[1];
      shifted_out[1] = shifted_out[0];
      shifted_out[0] = evicted;

      next_sum = int'(word_sum) + words;
      word_sum = (next_sum > TOTAL_MAX) ? '1 : next_sum[TOTAL_W-1:0];
      next_sum = int'(cross_sum) + crosses;
      cross_sum = (next_sum > TOTAL_MAX) ? '1 : next_sum[TOTAL_W-1:0];

      c++;
      if (c >= w) begin
         c = 0;
         if (rows_done < 3)
            rows_done++;
      end
      col_pos = c;

      totals.word_total  = word_sum;
      totals.cross_total = cross_sum;
      totals.grid_done   = item_in.grid_last;
      if (item_in.grid_last)
         clear_grid();
   endtask

   always @(posedge clock) begin : monitor
      rsp_type oldest, fresh;
      logic [DATA_W-1:0] reg_now;
      logic known_reg;
      if (reset) begin
         row_width  = RST_ROW_WIDTH;
         pat_first  = RST_PAT_FIRST;
         pat_second = RST_PAT_SECOND;
         pat_third  = RST_PAT_THIRD;
         pat_fourth = RST_PAT_FOURTH;
         diag_sum   = RST_DIAGONAL_SUM;
         clear_grid();
         totals_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            reg_now = '0;
            known_reg = 1'b1;
            case (reg_idx_type'(csr_paddr[ADDR_W-1:2]))
               REG_ROW_WIDTH: begin
                  if (csr_pwrite)
                     row_width = csr_pwdata[ROWW_W-1:0];
                  reg_now[ROWW_W-1:0] = row_width;
               end
               REG_PATTERN_FIRST: begin
                  if (csr_pwrite)
                     pat_first = csr_pwdata[CHAR_W-1:0];
                  reg_now[CHAR_W-1:0] = pat_first;
               end
               REG_PATTERN_SECOND: begin
                  if (csr_pwrite)
                     pat_second = csr_pwdata[CHAR_W-1:0];
                  reg_now[CHAR_W-1:0] = pat_second;
               end
               REG_PATTERN_THIRD: begin
                  if (csr_pwrite)
                     pat_third = csr_pwdata[CHAR_W-1:0];
                  reg_now[CHAR_W-1:0] = pat_third;
               end
               REG_PATTERN_FOURTH: begin
                  if (csr_pwrite)
                     pat_fourth = csr_pwdata[CHAR_W-1:0];
                  reg_now[CHAR_W-1:0] = pat_fourth;
               end
               REG_DIAGONAL_SUM: begin
                  if (csr_pwrite)
                     diag_sum = csr_pwdata[DSUM_W-1:0];
                  reg_now[DSUM_W-1:0] = diag_sum;
               end
               default: known_reg = 1'b0;
            endcase
            if (!csr_pwrite && known_reg && csr_prdata !== reg_now)
               note_failure($sformatf("register read at %0d: expected %0h, got %0h",
                                      csr_paddr, reg_now, csr_prdata));
         end

         if (rsp_valid && rsp_ready) begin
            if (totals_q.size() == 0) begin
               note_failure($sformatf("result with no item waiting: words %0d crosses %0d done %0b",
                                      rsp_data.word_total, rsp_data.cross_total,
                                      rsp_data.grid_done));
            end else begin
               oldest = totals_q.pop_front();
               if (rsp_data.word_total !== oldest.word_total ||
                   rsp_data.cross_total !== oldest.cross_total ||
                   rsp_data.grid_done !== oldest.grid_done)
                  note_failure($sformatf({"result mismatch: expected words %0d crosses %0d ",
                                          "done %0b, got words %0d crosses %0d done %0b"},
                                         oldest.word_total, oldest.cross_total,
                                         oldest.grid_done, rsp_data.word_total,
                                         rsp_data.cross_total, rsp_data.grid_done));
            end
         end

         if (req_valid && req_ready) begin
            advance_grid(req_data, fresh);
            totals_q.push_back(fresh);
         end
      end
      fail_count    <= errors;
      pending_count <= totals_q.size();
   end

endmodule

>>> test/tb.sv
// Testbench top for the grid word and cross counter: streams directed and random
// grids under changing register settings with random idling on both channels.
// Depends on gwc_pkg, the counter RTL and gwc_total_checker, which does the comparing.
module tb;
   import gwc_pkg::*;

   localparam int ITEM_TARGET    = 1950;
   localparam int WATCHDOG_LIMIT = 1000;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [DATA_W-1:0] csr_pwdata = '0;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;
   int                fail_count;
   int                pending_count;

   logic [CHAR_W-1:0] letters [4] = '{RST_PAT_FIRST, RST_PAT_SECOND,
                                      RST_PAT_THIRD, RST_PAT_FOURTH};
   int cells_sent = 0;
   int send_calm = 0;
   int take_calm = 0;
   int stall_cycles = 0;

   grid_word_and_cross_counter dut (.*);

   gwc_total_checker totals_check (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Now and then a side runs a stretch of items without any idling.
   function automatic int idle_cycles(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, 8);
   endfunction

   function automatic logic [CHAR_W-1:0] grid_letter();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10)
         return CHAR_W'($urandom_range(0, 255));
      if (r < 28)
         return letters[0];
      if (r < 52)
         return letters[1];
      if (r < 76)
         return letters[2];
      return letters[3];
   endfunction

   task automatic send_cell(input logic [CHAR_W-1:0] ch, input logic is_last);
      int gap;
      gap = idle_cycles(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{grid_char: ch, grid_last: is_last};
      do @(posedge clock); while (!req_ready);
      cells_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic csr_access(input logic is_write, input reg_idx_type idx,
                             input logic [DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_registers();
      for (int i = REG_ROW_WIDTH; i <= REG_DIAGONAL_SUM; i++)
         csr_access(1'b0, reg_idx_type'(i), '0);
   endtask

   task automatic run_grid(input int grid_no);
      int r, w_raw, w_eff, cells, cut;
      logic [DSUM_W-1:0] dsum;
      // Short grids of arbitrary characters that close at any point.
      if ($urandom_range(0, 99) < 8) begin
         cells = $urandom_range(1, 16);
         for (int i = 0; i < cells; i++)
            send_cell(CHAR_W'($urandom_range(0, 255)), i == cells - 1);
         return;
      end

      settle();
      if ($urandom_range(0, 3) == 0) begin
         letters = '{RST_PAT_FIRST, RST_PAT_SECOND, RST_PAT_THIRD, RST_PAT_FOURTH};
      end else begin
         for (int k = 0; k < 4; k++) begin
            r = $urandom_range(0, 9);
            if (r == 0)
               letters[k] = '0;
            else if (r == 1)
               letters[k] = '1;
            else if (r < 6)
               letters[k] = CHAR_W'($urandom_range("A", "Z"));
            else
               letters[k] = CHAR_W'($urandom_range(0, 255));
         end
      end
      // A word equal to its own reverse is counted once per direction.
      if ($urandom_range(0, 4) == 0) begin
         letters[3] = letters[0];
         letters[2] = letters[1];
      end
      csr_access(1'b1, REG_PATTERN_FIRST, DATA_W'(letters[0]));
      csr_access(1'b1, REG_PATTERN_SECOND, DATA_W'(letters[1]));
      csr_access(1'b1, REG_PATTERN_THIRD, DATA_W'(letters[2]));
      csr_access(1'b1, REG_PATTERN_FOURTH, DATA_W'(letters[3]));

      r = $urandom_range(0, 99);
      if (r < 8)
         dsum = '0;
      else if (r < 16)
         dsum = '1;
      else if (r < 20)
         dsum = 9'd510;
      else if (r < 35)
         dsum = DSUM_W'($urandom_range(0, (1 << DSUM_W) - 1));
      else
         dsum = DSUM_W'(letters[1]) + DSUM_W'(letters[3]);
      csr_access(1'b1, REG_DIAGONAL_SUM, DATA_W'(dsum));

      if (grid_no == 3) begin
         w_raw = MAX_WIDTH;
      end else if (grid_no == 7) begin
         w_raw = $urandom_range(MAX_WIDTH + 1, (1 << ROWW_W) - 1);
      end else begin
         r = $urandom_range(0, 99);
         if (r < 6)
            w_raw = 0;
         else if (r < 14)
            w_raw = 1;
         else if (r < 24)
            w_raw = $urandom_range(13, 40);
         else
            w_raw = $urandom_range(2, 12);
      end
      w_eff = (w_raw < 1) ? 1 : (w_raw > MAX_WIDTH) ? MAX_WIDTH : w_raw;
      csr_access(1'b1, REG_ROW_WIDTH, w_raw);
      if ($urandom_range(0, 3) == 0)
         read_registers();

      if (w_eff >= 200)
         cells = w_eff + $urandom_range(1, 12);
      else if (w_eff == 1)
         cells = $urandom_range(4, 24);
      else
         cells = w_eff * $urandom_range(3, 7) + $urandom_range(0, w_eff - 1);
      if ($urandom_range(0, 9) == 0)
         cells = $urandom_range(1, cells);
      // The width may only shrink in the middle of a grid.
      cut = ($urandom_range(0, 3) == 0 && cells > 1) ? $urandom_range(1, cells - 1) : 0;
      for (int i = 0; i < cells; i++) begin
         if (cut != 0 && i == cut) begin
            settle();
            csr_access(1'b1, REG_ROW_WIDTH, $urandom_range(0, w_eff));
         end
         send_cell(grid_letter(), i == cells - 1);
      end
   endtask

   initial begin : result_sink
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = idle_cycles(take_calm);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : stimulus
      string square;
      string column;
      int grid_no;
      square = "XMASMMMMAAAASSSS";
      column = "XMASAMX";
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      read_registers();

      csr_access(1'b1, REG_ROW_WIDTH, 4);
      for (int i = 0; i < square.len(); i++)
         send_cell(square[i], i == square.len() - 1);
      settle();
      csr_access(1'b1, REG_ROW_WIDTH, 0);
      for (int i = 0; i < column.len(); i++)
         send_cell(column[i], 1'b0);
      send_cell('0, 1'b0);
      send_cell('1, 1'b1);

      grid_no = 0;
      while (cells_sent < ITEM_TARGET) begin
         run_grid(grid_no);
         grid_no++;
      end
      settle();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable)) begin
         stall_cycles <= 0;
      end else if (stall_cycles < WATCHDOG_LIMIT) begin
         stall_cycles <= stall_cycles + 1;
      end else begin
         $display("Simulation FAILED");
         $finish;
      end
   end

endmodule
